### hdl/gru_cell_step_macros.svh
// Assertion macros for the gru_cell_step block.
// Used by modules under hdl; no other dependencies.
`ifndef GRU_CELL_STEP_MACROS_SVH
`define GRU_CELL_STEP_MACROS_SVH
`ifndef SYNTH
`define GRU_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("gru check failed");
`define GRU_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("gru check failed");
`else
`define GRU_ASSERT_IMPL(label, clk, rst_n, a, c)
`define GRU_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

### hdl/gru_pkg.sv
// Shared types and constants for the gru_cell_step block.
// No dependencies.
`default_nettype none
package gru_pkg;
  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_BIAS   = 2'd1,
    OP_INPUT  = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  localparam int unsigned ACC_W = 48;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ZR   = 7'b0000010,
    S_RH   = 7'b0000100,
    S_CAND = 7'b0001000,
    S_UPD  = 7'b0010000,
    S_MIX  = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  // control word broadcast to the row of cells
  typedef struct packed {
    logic clear;    // zero h
    logic acc_clr;  // zero gate accumulators
    logic acc_en;   // accumulate product into gate accumulator
    logic [1:0] sel;// which gate accumulator
    logic rh_en;    // form r*h
    logic fin_en;   // finish z and candidate
    logic mix_en;   // compute new h
    logic shift;    // rotate hidden ring for emission
  } cell_ctl_t;

  function automatic logic signed [15:0] to_q12(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] q;
    begin
      q = (a + ACC_W'(2048)) >>> 12;
      if (q > ACC_W'(32767)) to_q12 = 16'sh7fff;
      else if (q < -ACC_W'(32768)) to_q12 = 16'sh8000;
      else to_q12 = q[15:0];
    end
  endfunction

  function automatic logic signed [15:0] hard_sig(input logic signed [15:0] s);
    logic signed [16:0] y;
    begin
      y = 17'sd2048 + 17'(s >>> 2);
      if (y < 0) hard_sig = 16'sd0;
      else if (y > 17'sd4096) hard_sig = 16'sd4096;
      else hard_sig = y[15:0];
    end
  endfunction

  function automatic logic signed [15:0] hard_tanh(input logic signed [15:0] s);
    begin
      if (s > 16'sd4096) hard_tanh = 16'sd4096;
      else if (s < -16'sd4096) hard_tanh = -16'sd4096;
      else hard_tanh = s;
    end
  endfunction
endpackage
`default_nettype wire

### hdl/gru_cell_step.sv
// GRU time step, Q4.12: the last input element of a step starts a sequencer that feeds
// the cell row one column per cycle: the z and r gates, then r*h, then the candidate,
// then z and the candidate are finished and mixed into h; then H words go out if the
// step is emitted (emit_all_steps set or sequence end).
// Input is held off until the step's words are out; weight memory gives one word per row
// per cycle. Reset (rst_n, synchronous) zeroes h, the input count and sets emit_all_steps.
`default_nettype none
`include "gru_cell_step_macros.svh"
module gru_cell_step #(
  parameter int N_IN = 16,
  parameter int N_HID = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [1:0] in_opcode,
  input  wire logic [1:0] in_gate,
  input  wire logic [5:0] in_row,
  input  wire logic [6:0] in_column,
  input  wire logic signed [15:0] in_value,
  input  wire logic in_last_element,
  input  wire logic in_sequence_end,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [15:0] out_hidden_value,
  output logic [5:0] out_hidden_index,
  output logic out_last_result,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic cfg_emit_all_steps
);
  import gru_pkg::*;
  localparam int COMB = N_IN + N_HID;
  localparam int CW = $clog2(COMB + 1);
  localparam int IW = (N_IN > 1) ? $clog2(N_IN) : 1;
  localparam int HW = (N_HID > 1) ? $clog2(N_HID) : 1;
  localparam int MA = $clog2(3 * COMB);

  state_t state_r, state_nxt;
  logic emit_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0] gsel_r, gsel_nxt;
  logic [6:0] icnt_r;
  logic [HW:0] ecnt_r;
  logic emit_pend_r;
  logic signed [15:0] inbuf_r [N_IN];
  logic signed [15:0] bias_r [3][N_HID];
  logic signed [15:0] h [N_HID];
  logic signed [15:0] rh [N_HID];
  logic signed [15:0] operand_r;
  cell_ctl_t ctl;
  logic acc_go_r;
  logic [1:0] acc_sel_r;
  logic accept;
  logic [MA-1:0] waddr, raddr;
  logic wr_ok;

  assign accept = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign wr_ok = accept && in_opcode == OP_WEIGHT && in_gate <= 2'd2 &&
                 32'(in_row) < N_HID && 32'(in_column) < COMB;
  assign waddr = MA'(32'(in_gate) * COMB + 32'(in_column));
  assign raddr = MA'(32'(gsel_r) * COMB + 32'(cnt_r));

  // weight memory: one bank per row, read one column per cycle
  genvar gj;
  generate
    for (gj = 0; gj < N_HID; gj++) begin : g_row
      logic signed [15:0] mem [3 * COMB];
      logic signed [15:0] rd_r;
      always_ff @(posedge clk) begin
        if (wr_ok && 32'(in_row) == gj) mem[waddr] <= in_value;
        rd_r <= mem[raddr];
      end
      gru_cell u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .weight(rd_r), .operand(operand_r),
        .bias_z(bias_r[0][gj]), .bias_r(bias_r[1][gj]), .bias_c(bias_r[2][gj]),
        .h_in(h[(gj + 1) % N_HID]), .h_out(h[gj]), .rh_out(rh[gj])
      );
    end
  endgenerate

  logic in_phase;
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    gsel_nxt = gsel_r;
    in_phase = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept && in_opcode == OP_INPUT && in_last_element) begin
          state_nxt = S_ZR; cnt_nxt = '0; gsel_nxt = 2'd0;
        end
      end
      S_ZR: begin
        in_phase = 1'b1;
        if (32'(cnt_r) == COMB - 1) begin
          cnt_nxt = '0;
          if (gsel_r == 2'd1) state_nxt = S_RH;
          gsel_nxt = gsel_r + 2'd1;
        end else cnt_nxt = cnt_r + 1'b1;
      end
      S_RH: begin
        if (cnt_r == CW'(2)) begin state_nxt = S_CAND; cnt_nxt = '0; end
        else cnt_nxt = cnt_r + 1'b1;
      end
      S_CAND: begin
        in_phase = 1'b1;
        if (32'(cnt_r) == COMB - 1) begin state_nxt = S_UPD; cnt_nxt = '0; end
        else cnt_nxt = cnt_r + 1'b1;
      end
      S_UPD: begin
        if (cnt_r == CW'(3)) begin state_nxt = S_MIX; cnt_nxt = '0; end
        else cnt_nxt = cnt_r + 1'b1;
      end
      S_MIX: state_nxt = emit_pend_r ? S_EMIT : S_IDLE;
      S_EMIT: if (out_ready && 32'(ecnt_r) == N_HID - 1) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // operand for the column being read (registered, like the memory read)
  logic signed [15:0] opnd_nxt;
  always_comb begin
    opnd_nxt = '0;
    if (32'(cnt_r) < N_IN) opnd_nxt = inbuf_r[cnt_r[IW-1:0]];
    else if (state_r == S_CAND) opnd_nxt = rh[HW'(32'(cnt_r) - N_IN)];
    else opnd_nxt = h[HW'(32'(cnt_r) - N_IN)];
  end

  always_comb begin
    ctl = '0;
    ctl.clear = accept && in_opcode == OP_CLEAR;
    ctl.acc_clr = accept && in_opcode == OP_INPUT && in_last_element;
    ctl.acc_en = acc_go_r;
    ctl.sel = acc_sel_r;
    ctl.rh_en = state_r == S_RH && cnt_r == CW'(2);
    ctl.fin_en = state_r == S_UPD && cnt_r == CW'(3);
    ctl.mix_en = state_r == S_MIX;
    ctl.shift = state_r == S_EMIT && out_ready;
  end

  assign out_valid = state_r == S_EMIT;
  assign out_hidden_value = h[0];
  assign out_hidden_index = 6'(ecnt_r);
  assign out_last_result = 32'(ecnt_r) == N_HID - 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      emit_r <= 1'b1;
      icnt_r <= '0;
      ecnt_r <= '0;
      emit_pend_r <= 1'b0;
      acc_go_r <= 1'b0;
      cnt_r <= '0;
      gsel_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      gsel_r <= gsel_nxt;
      acc_go_r <= in_phase;
      if (cfg_valid && cfg_ready) emit_r <= cfg_emit_all_steps;
      if (accept && in_opcode == OP_INPUT) begin
        if (in_last_element) begin
          icnt_r <= '0;
          emit_pend_r <= emit_r || in_sequence_end;
        end else if (32'(icnt_r) < N_IN) icnt_r <= icnt_r + 7'd1;
      end
      if (state_r == S_MIX) ecnt_r <= '0;
      else if (ctl.shift) ecnt_r <= ecnt_r + 1'b1;
    end
    acc_sel_r <= (state_r == S_CAND) ? 2'd2 : gsel_r;
    operand_r <= opnd_nxt;
    if (accept && in_opcode == OP_INPUT && 32'(icnt_r) < N_IN)
      inbuf_r[IW'(icnt_r)] <= in_value;
    if (accept && in_opcode == OP_BIAS && in_gate <= 2'd2 && 32'(in_row) < N_HID)
      bias_r[in_gate][HW'(in_row)] <= in_value;
  end

  // accumulators are cleared at step start; these checks cover ready, emission and the mix exit
  `GRU_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, state_r == S_IDLE)
  `GRU_ASSERT_IMPL(a_emit_only, clk, rst_n, out_valid, emit_pend_r)
  `GRU_ASSERT_NEXT(a_mix_next, clk, rst_n, state_r == S_MIX, state_r == S_EMIT || state_r == S_IDLE)
endmodule
`default_nettype wire

### hdl/gru_cell.sv
// One hidden row of the GRU: holds h[j], three gate accumulators and z.
// Uses gru_pkg; passes its h to cell j-1 (wrapping) when the ring shifts.
`default_nettype none
module gru_cell (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire gru_pkg::cell_ctl_t ctl,
  input  wire logic signed [15:0] weight,
  input  wire logic signed [15:0] operand,
  input  wire logic signed [15:0] bias_z,
  input  wire logic signed [15:0] bias_r,
  input  wire logic signed [15:0] bias_c,
  input  wire logic signed [15:0] h_in,
  output logic signed [15:0] h_out,
  output logic signed [15:0] rh_out
);
  import gru_pkg::*;
  logic signed [15:0] h_r, h_nxt, z_r, z_nxt, rh_r, rh_nxt, c_r, c_nxt;
  logic signed [ACC_W-1:0] acc_r [3];
  logic signed [ACC_W-1:0] acc_nxt [3];
  logic signed [31:0] prod_r;
  logic signed [31:0] prod_nxt;
  logic vld_r;
  logic [1:0] sel_r;
  logic signed [15:0] r_q;

  assign prod_nxt = weight * operand;
  assign r_q = hard_sig(to_q12(acc_r[1] + (ACC_W'(bias_r) <<< 12)));

  always_comb begin
    acc_nxt = acc_r;
    if (vld_r) acc_nxt[sel_r] = acc_r[sel_r] + ACC_W'(prod_r);
    if (ctl.acc_clr) begin
      acc_nxt[0] = '0; acc_nxt[1] = '0; acc_nxt[2] = '0;
    end
    rh_nxt = rh_r;
    if (ctl.rh_en) rh_nxt = to_q12(ACC_W'(r_q * h_r));
    z_nxt = z_r;
    c_nxt = c_r;
    if (ctl.fin_en) begin
      z_nxt = hard_sig(to_q12(acc_r[0] + (ACC_W'(bias_z) <<< 12)));
      c_nxt = hard_tanh(to_q12(acc_r[2] + (ACC_W'(bias_c) <<< 12)));
    end
    h_nxt = h_r;
    if (ctl.mix_en)
      h_nxt = to_q12(ACC_W'(z_r * h_r) + ACC_W'((16'sd4096 - z_r) * c_r));
    if (ctl.shift) h_nxt = h_in;
    if (ctl.clear) h_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= '0;
      vld_r <= 1'b0;
    end else begin
      h_r <= h_nxt;
      vld_r <= ctl.acc_en;
    end
    sel_r <= ctl.sel;
    prod_r <= prod_nxt;
    acc_r <= acc_nxt;
    rh_r <= rh_nxt;
    z_r <= z_nxt;
    c_r <= c_nxt;
  end

  assign h_out = h_r;
  assign rh_out = rh_r;
endmodule
`default_nettype wire
